### rtl/assert_macros.svh
// Assertion macros for the vector angle block.
// Used by the checker module only; needs aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// checked only out of reset
`define VAB3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked at every edge, reset included
`define VAB3_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`endif

### rtl/vab3_pkg.sv
// Types, constants and constant functions for the vector angle block.
// No dependencies.
package vab3_pkg;

    localparam int PW     = 116;  // normalised radicand width
    localparam int RW     = 58;   // root width, one bit per sqrt cell
    localparam int QW     = 64;   // rotator word width
    localparam int QF     = 60;   // angle fraction bits in the rotator
    localparam int NSTEPS = 58;
    localparam logic [QW-1:0] PI_QF = 64'h3243F6A8885A308D;

    typedef struct packed {
        logic [PW-1:0] rem;
        logic [RW-1:0] root;
        logic [RW-1:0] xs;
        logic          dneg;
        logic          degen;
    } vab3_sq_t;

    typedef struct packed {
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
        logic                 degen;
    } vab3_cd_t;

    // atan(2^-i) in Q60, series truncated term by term
    function automatic logic signed [QW-1:0] vab3_atan(input int i);
        logic signed [QW-1:0] acc;
        logic [QW-1:0]        t;
        int                   k;
        int                   sh;
        acc = '0;
        if (i == 0) begin
            acc = $signed(PI_QF >> 2);
        end else begin
            for (k = 0; k < 64; k++) begin
                sh = i * (2 * k + 1);
                if (sh < QF) begin
                    t = (64'd1 << (QF - sh)) / 64'(2 * k + 1);
                    acc = k[0] ? acc - $signed(t) : acc + $signed(t);
                end
            end
        end
        return acc;
    endfunction

    // clamp to [0, pi] and round half up to frac bits
    function automatic logic [QW-1:0] vab3_code(input logic signed [QW-1:0] z,
                                                 input int frac);
        logic [QW-1:0] u;
        int            sh;
        sh = QF - frac;
        u  = z;
        if (z[QW-1]) begin
            u = '0;
        end else if (u > PI_QF) begin
            u = PI_QF;
        end
        return (u + (64'd1 << (sh - 1))) >> sh;
    endfunction

endpackage

### rtl/vector_angle_between_3d_top.sv
// Angle between two 3D vectors: front end, sqrt chain of 58 cells, 58 rotator cells.
// Pipeline: 7 front stages, 58 sqrt, 58 rotator, 1 output register.
// Throughput one word per cycle; the whole pipeline advances whenever the output
// register is empty or being taken.
// Synchronous active-low reset clears the valid bits only; no other state.
// Depends on vab3_pkg, vab3_front, vab3_sqrt_cell, vab3_cordic_cell.
module vector_angle_between_3d_top #(
    parameter int COORD_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 14
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [COORD_WIDTH-1:0]  s_origin_x,
    input  logic signed [COORD_WIDTH-1:0]  s_origin_y,
    input  logic signed [COORD_WIDTH-1:0]  s_origin_z,
    input  logic signed [COORD_WIDTH-1:0]  s_first_x,
    input  logic signed [COORD_WIDTH-1:0]  s_first_y,
    input  logic signed [COORD_WIDTH-1:0]  s_first_z,
    input  logic signed [COORD_WIDTH-1:0]  s_second_x,
    input  logic signed [COORD_WIDTH-1:0]  s_second_y,
    input  logic signed [COORD_WIDTH-1:0]  s_second_z,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ANGLE_FRAC_BITS+1:0]     m_angle,
    output logic                           m_degenerate
);
    import vab3_pkg::*;

    localparam int AW = ANGLE_FRAC_BITS + 2;
    localparam logic [AW-1:0] HALF_PI_CODE =
        AW'(vab3_code($signed(PI_QF >> 1), ANGLE_FRAC_BITS));

    logic     en;
    logic     sq_valid [NSTEPS+1];
    vab3_sq_t sq_data  [NSTEPS+1];
    logic     cd_valid [NSTEPS+1];
    vab3_cd_t cd_data  [NSTEPS+1];

    logic          m_valid_reg;
    logic [AW-1:0] angle_reg, angle_next;
    logic          degen_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    vab3_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .origin_x (s_origin_x),
        .origin_y (s_origin_y),
        .origin_z (s_origin_z),
        .first_x  (s_first_x),
        .first_y  (s_first_y),
        .first_z  (s_first_z),
        .second_x (s_second_x),
        .second_y (s_second_y),
        .second_z (s_second_z),
        .out_valid(sq_valid[0]),
        .out_data (sq_data[0])
    );

    for (genvar g = 0; g < NSTEPS; g++) begin : g_sqrt
        vab3_sqrt_cell #(.STEP(RW - 1 - g)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (sq_valid[g]),
            .in_data  (sq_data[g]),
            .out_valid(sq_valid[g+1]),
            .out_data (sq_data[g+1])
        );
    end

    // quadrant set-up from the sign of the dot product
    always_comb begin
        cd_valid[0]     = sq_valid[NSTEPS];
        cd_data[0].degen = sq_data[NSTEPS].degen;
        if (!sq_data[NSTEPS].dneg) begin
            cd_data[0].x = $signed(QW'(sq_data[NSTEPS].xs));
            cd_data[0].y = $signed(QW'(sq_data[NSTEPS].root));
            cd_data[0].z = '0;
        end else begin
            cd_data[0].x = $signed(QW'(sq_data[NSTEPS].root));
            cd_data[0].y = $signed(QW'(sq_data[NSTEPS].xs));
            cd_data[0].z = $signed(PI_QF >> 1);
        end
    end

    for (genvar g = 0; g < NSTEPS; g++) begin : g_cordic
        vab3_cordic_cell #(.STEP(g)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (cd_valid[g]),
            .in_data  (cd_data[g]),
            .out_valid(cd_valid[g+1]),
            .out_data (cd_data[g+1])
        );
    end

    always_comb begin
        angle_next = cd_data[NSTEPS].degen ? HALF_PI_CODE
                   : AW'(vab3_code(cd_data[NSTEPS].z, ANGLE_FRAC_BITS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= cd_valid[NSTEPS];
        end
        if (en) begin
            angle_reg <= angle_next;
            degen_reg <= cd_data[NSTEPS].degen;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_angle      = angle_reg;
    assign m_degenerate = degen_reg;

endmodule

### rtl/vab3_front.sv
// Front end: differences, lengths, dot product, cross term and normalisation.
// Depends on vab3_pkg.
module vab3_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic signed [COORD_WIDTH-1:0] first_z,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_y,
    input  logic signed [COORD_WIDTH-1:0] second_z,
    output logic                          out_valid,
    output vab3_pkg::vab3_sq_t            out_data
);
    import vab3_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int LW = 2 * CW + 2;
    localparam int DW = LW + 1;

    logic [6:0] vld_reg;

    logic signed [CW:0]   a_reg [3];
    logic signed [CW:0]   b_reg [3];
    logic signed [LW-1:0] aa_reg [3];
    logic signed [LW-1:0] bb_reg [3];
    logic signed [LW-1:0] ab_reg [3];

    logic [LW-1:0] la_reg, lb_reg, ad3_reg;
    logic          dneg3_reg, degen3_reg;
    logic signed [DW-1:0] d_next;
    logic [LW-1:0] la_next, lb_next, ad_next;

    logic [QW-1:0] pp_reg [8];
    logic [LW-1:0] ad4_reg, ad5_reg, ad6_reg;
    logic          dneg4_reg, dneg5_reg, dneg6_reg;
    logic          degen4_reg, degen5_reg, degen6_reg;
    logic [QW-1:0] la64, lb64, ad64;

    logic [127:0]  p_next, q_next;
    logic [PW-1:0] p_reg, c2_reg, c2b_reg;

    logic [127:0]  pw;
    logic [7:0]    nz_next, nz_reg;
    logic [4:0]    cnt_next [8];
    logic [4:0]    cnt_reg [8];

    logic [6:0]    bl;
    logic [5:0]    m;
    vab3_sq_t      out_next, out_reg;

    always_comb begin
        la_next = LW'(aa_reg[0]) + LW'(aa_reg[1]) + LW'(aa_reg[2]);
        lb_next = LW'(bb_reg[0]) + LW'(bb_reg[1]) + LW'(bb_reg[2]);
        d_next  = DW'(ab_reg[0]) + DW'(ab_reg[1]) + DW'(ab_reg[2]);
        ad_next = d_next[DW-1] ? LW'(-d_next) : LW'(d_next);
    end

    assign la64 = QW'(la_reg);
    assign lb64 = QW'(lb_reg);
    assign ad64 = QW'(ad3_reg);

    always_comb begin
        p_next = {pp_reg[3], pp_reg[0]} + (128'(pp_reg[1]) << 32)
                 + (128'(pp_reg[2]) << 32);
        q_next = {pp_reg[7], pp_reg[4]} + (128'(pp_reg[5]) << 32)
                 + (128'(pp_reg[6]) << 32);
    end

    always_comb begin
        pw = 128'(p_reg);
        for (int j = 0; j < 8; j++) begin
            nz_next[j]  = |pw[16*j +: 16];
            cnt_next[j] = '0;
            for (int k = 0; k < 16; k++) begin
                if (pw[16*j + k]) begin
                    cnt_next[j] = 5'(k + 1);
                end
            end
        end
    end

    always_comb begin
        bl = '0;
        for (int j = 0; j < 8; j++) begin
            if (nz_reg[j]) begin
                bl = 7'(16 * j) + 7'(cnt_reg[j]);
            end
        end
        m              = 6'((7'(PW) - bl) >> 1);
        out_next.rem   = c2b_reg << {m, 1'b0};
        out_next.root  = '0;
        out_next.xs    = RW'(ad6_reg) << m;
        out_next.dneg  = dneg6_reg;
        out_next.degen = degen6_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
        if (en) begin
            a_reg[0] <= {first_x[CW-1], first_x} - {origin_x[CW-1], origin_x};
            a_reg[1] <= {first_y[CW-1], first_y} - {origin_y[CW-1], origin_y};
            a_reg[2] <= {first_z[CW-1], first_z} - {origin_z[CW-1], origin_z};
            b_reg[0] <= {second_x[CW-1], second_x} - {origin_x[CW-1], origin_x};
            b_reg[1] <= {second_y[CW-1], second_y} - {origin_y[CW-1], origin_y};
            b_reg[2] <= {second_z[CW-1], second_z} - {origin_z[CW-1], origin_z};
            for (int i = 0; i < 3; i++) begin
                aa_reg[i] <= a_reg[i] * a_reg[i];
                bb_reg[i] <= b_reg[i] * b_reg[i];
                ab_reg[i] <= a_reg[i] * b_reg[i];
            end
            la_reg     <= la_next;
            lb_reg     <= lb_next;
            ad3_reg    <= ad_next;
            dneg3_reg  <= d_next[DW-1];
            degen3_reg <= (la_next == '0) || (lb_next == '0);
            pp_reg[0]  <= la64[31:0]  * lb64[31:0];
            pp_reg[1]  <= la64[31:0]  * lb64[63:32];
            pp_reg[2]  <= la64[63:32] * lb64[31:0];
            pp_reg[3]  <= la64[63:32] * lb64[63:32];
            pp_reg[4]  <= ad64[31:0]  * ad64[31:0];
            pp_reg[5]  <= ad64[31:0]  * ad64[63:32];
            pp_reg[6]  <= ad64[63:32] * ad64[31:0];
            pp_reg[7]  <= ad64[63:32] * ad64[63:32];
            ad4_reg    <= ad3_reg;
            dneg4_reg  <= dneg3_reg;
            degen4_reg <= degen3_reg;
            p_reg      <= PW'(p_next);
            c2_reg     <= PW'(p_next - q_next);
            ad5_reg    <= ad4_reg;
            dneg5_reg  <= dneg4_reg;
            degen5_reg <= degen4_reg;
            nz_reg     <= nz_next;
            cnt_reg    <= cnt_next;
            c2b_reg    <= c2_reg;
            ad6_reg    <= ad5_reg;
            dneg6_reg  <= dneg5_reg;
            degen6_reg <= degen5_reg;
            out_reg    <= out_next;
        end
    end

    assign out_valid = vld_reg[6];
    assign out_data  = out_reg;

endmodule

### rtl/vab3_sqrt_cell.sv
// One digit of the square-root chain: tries root bit STEP.
// Depends on vab3_pkg.
module vab3_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  vab3_pkg::vab3_sq_t in_data,
    output logic               out_valid,
    output vab3_pkg::vab3_sq_t out_data
);
    import vab3_pkg::*;

    logic [PW+1:0] trial, remx;
    vab3_sq_t      data_next, data_reg;
    logic          valid_reg;

    always_comb begin
        remx  = {2'b00, in_data.rem};
        trial = ((PW+2)'(in_data.root) << (STEP + 1)) + ((PW+2)'(1) << (2 * STEP));
        data_next = in_data;
        if (remx >= trial) begin
            data_next.rem  = PW'(remx - trial);
            data_next.root = in_data.root | (RW'(1) << STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/vab3_cordic_cell.sv
// One vectoring rotation of the arctangent chain, shift STEP.
// Depends on vab3_pkg.
module vab3_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  vab3_pkg::vab3_cd_t in_data,
    output logic               out_valid,
    output vab3_pkg::vab3_cd_t out_data
);
    import vab3_pkg::*;

    localparam logic signed [QW-1:0] ATAN = vab3_atan(STEP);

    logic signed [QW-1:0] dx, dy;
    vab3_cd_t             data_next, data_reg;
    logic                 valid_reg;

    always_comb begin
        dx = in_data.y >>> STEP;
        dy = in_data.x >>> STEP;
        data_next = in_data;
        if (!in_data.y[QW-1]) begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ATAN;
        end else begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/vab3_checker.sv
// Port-level checks for the vector angle block, bound to the top level.
// Depends on vab3_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vab3_checker #(
    parameter int ANGLE_FRAC_BITS = 14
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [ANGLE_FRAC_BITS+1:0] m_angle,
    input logic                       m_degenerate
);
    import vab3_pkg::*;

    localparam int AW = ANGLE_FRAC_BITS + 2;
    localparam logic [AW-1:0] HALF_CODE = AW'(vab3_code($signed(PI_QF >> 1), ANGLE_FRAC_BITS));
    localparam logic [AW-1:0] PI_CODE   = AW'(vab3_code($signed(PI_QF), ANGLE_FRAC_BITS));

    `VAB3_ASSERT(a_degen_half, m_valid && m_degenerate |-> m_angle == HALF_CODE, "degenerate word not pi/2")
    `VAB3_ASSERT(a_angle_range, m_valid |-> m_angle <= PI_CODE, "angle above pi")
    `VAB3_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid, "result word dropped")
    `VAB3_ASSERT(a_ready_rule, s_ready == (!m_valid || m_ready), "input ready out of step with output")
    `VAB3_ASSERT_ALL(a_reset_empty, !aresetn |=> !m_valid, "result word after reset")

endmodule

bind vector_angle_between_3d_top vab3_checker #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_vab3_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_angle     (m_angle),
    .m_degenerate(m_degenerate)
);

### tb/tb_top.sv
// Self-checking bench for vector_angle_between_3d_top: drives coordinate words, predicts
// each angle with a local 128-bit sqrt and CORDIC model, checks results in order.
// Depends on vab3_pkg and the block's RTL.
module tb_top;
    import vab3_pkg::*;

    localparam int CW         = 16;
    localparam int FR         = 14;
    localparam int AW         = FR + 2;
    localparam int CYCLE_CAP  = 600000;
    localparam int DRAIN_WAIT = 140;
    localparam int LONG_HOLD  = 700;

    typedef logic signed [CW-1:0] coord_set_t [9];

    typedef struct packed {
        logic [AW-1:0] angle;
        logic          degen;
    } angle_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CW-1:0] s_coord [9] = '{default: '0};
    logic m_valid;
    logic m_ready = 1'b0;
    logic [AW-1:0] m_angle;
    logic m_degenerate;

    angle_word_t pending_angles [$];
    int          n_errors = 0;
    int          cycle_cnt = 0;
    int          hold_req = 0;
    bit          hold_tog = 1'b0;
    bit          hold_seen = 1'b0;
    bit          rx_calm = 1'b0;

    vector_angle_between_3d_top #(.COORD_WIDTH(CW), .ANGLE_FRAC_BITS(FR)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_origin_x(s_coord[0]), .s_origin_y(s_coord[1]), .s_origin_z(s_coord[2]),
        .s_first_x(s_coord[3]), .s_first_y(s_coord[4]), .s_first_z(s_coord[5]),
        .s_second_x(s_coord[6]), .s_second_y(s_coord[7]), .s_second_z(s_coord[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_angle(m_angle), .m_degenerate(m_degenerate)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic longint atan_q60(input int i);
        longint acc;
        longint t;
        int     sh;
        acc = 0;
        if (i == 0) return longint'(PI_QF >> 2);
        for (int k = 0; k < 64; k++) begin
            sh = i * (2 * k + 1);
            if (sh >= QF) break;
            t = longint'((64'd1 << (QF - sh)) / 64'(2 * k + 1));
            acc = k[0] ? acc - t : acc + t;
        end
        return acc;
    endfunction

    function automatic logic [AW-1:0] round_angle(input longint z);
        logic [63:0] u;
        u = (z < 0) ? 64'd0 : 64'(z);
        if (u > PI_QF) u = PI_QF;
        return AW'((u + (64'd1 << (QF - FR - 1))) >> (QF - FR));
    endfunction

    function automatic angle_word_t predict_angle(input coord_set_t c);
        angle_word_t  r;
        longint       a [3];
        longint       b [3];
        longint       dot, x, y, z, dx, dy, t;
        logic [63:0]  la, lb, ad, xs, s, cand;
        logic [127:0] prod, cross2, rad;
        int           nb, m;
        dot = 0;
        la = 0;
        lb = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'(c[3+i]) - longint'(c[i]);
            b[i] = longint'(c[6+i]) - longint'(c[i]);
            la += 64'(a[i] * a[i]);
            lb += 64'(b[i] * b[i]);
            dot += a[i] * b[i];
        end
        if (la == 0 || lb == 0) begin
            r.angle = round_angle(longint'(PI_QF >> 1));
            r.degen = 1'b1;
            return r;
        end
        prod = 128'(la) * 128'(lb);
        ad = (dot < 0) ? 64'(-dot) : 64'(dot);
        cross2 = prod - 128'(ad) * 128'(ad);
        nb = 0;
        for (int i = 0; i < 128; i++) if (prod[i]) nb = i + 1;
        m = (116 - nb) / 2;
        rad = cross2 << (2 * m);
        s = 0;
        for (int k = 57; k >= 0; k--) begin
            cand = s | (64'd1 << k);
            if (128'(cand) * 128'(cand) <= rad) s = cand;
        end
        xs = ad << m;
        if (dot >= 0) begin
            x = longint'(xs); y = longint'(s); z = 0;
        end else begin
            x = longint'(s); y = longint'(xs); z = longint'(PI_QF >> 1);
        end
        for (int i = 0; i < NSTEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            t = atan_q60(i);
            if (y >= 0) begin
                x += dx; y -= dy; z += t;
            end else begin
                x -= dx; y += dy; z -= t;
            end
        end
        r.angle = round_angle(z);
        r.degen = 1'b0;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(input coord_set_t c, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        for (int i = 0; i < 9; i++) s_coord[i] <= c[i];
        forever begin
            @(negedge aclk);
            if (s_ready) break;
        end
        @(posedge aclk);
        pending_angles.push_back(predict_angle(c));
    endtask

    task automatic send_pts(input int o0, o1, o2, f0, f1, f2, q0, q1, q2);
        coord_set_t c;
        c[0] = CW'(o0); c[1] = CW'(o1); c[2] = CW'(o2);
        c[3] = CW'(f0); c[4] = CW'(f1); c[5] = CW'(f2);
        c[6] = CW'(q0); c[7] = CW'(q1); c[8] = CW'(q2);
        send_word(c, pick_gap());
    endtask

    task automatic test_directed();
        send_pts(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pts(5, 5, 5, 5, 5, 5, 1, 2, 3);
        send_pts(0, 0, 0, 1, 2, 3, -7, 7, 7);
        send_pts(0, 0, 0, 1, 0, 0, 1, 0, 0);
        send_pts(0, 0, 0, 1, 0, 0, -1, 0, 0);
        send_pts(0, 0, 0, 1, 0, 0, 0, 1, 0);
        send_pts(0, 0, 0, 3, 4, 0, 6, 8, 0);
        send_pts(0, 0, 0, 1, 1, 0, 1, 0, 0);
        send_pts(0, 0, 0, -1, -1, 0, 1, 0, 0);
        send_pts(-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
        send_pts(-32768, -32768, -32768, 32767, 32767, 32767, -32768, -32768, -32767);
        send_pts(32767, 32767, 32767, -32768, -32768, -32768, 32767, -32768, 32767);
        send_pts(-32768, 0, 0, 32767, 0, 0, -32768, 32767, 0);
        send_pts(0, 0, 0, 32767, 32767, 32767, -32768, -32768, -32768);
        send_pts(0, 0, 0, 32767, 1, 0, 32767, 0, 0);
        send_pts(0, 0, 0, 32767, 32767, 32767, 32767, 32767, 32766);
        send_pts(0, 0, 0, 1, 0, 0, -32768, 1, 0);
        send_pts(100, -200, 300, 101, -200, 300, 100, -199, 300);
        send_pts(-1, -1, -1, -1, -1, -1, -1, -1, -1);
        send_pts(0, 0, 0, 2, 0, 0, 0, 0, -3);
    endtask

    task automatic send_random(input int n, input bit no_gaps);
        coord_set_t c;
        int kind, lim, k;
        for (int w = 0; w < n; w++) begin
            kind = $urandom_range(0, 9);
            lim = (kind < 4) ? 32767 : (kind < 7 ? 3 : 300);
            for (int i = 0; i < 9; i++) begin
                if (kind < 4) c[i] = CW'($urandom);
                else c[i] = CW'($urandom_range(0, 2 * lim) - lim);
            end
            if (kind == 8) begin
                // second point on the line through the first, either side
                k = $urandom_range(0, 1) ? 2 : -3;
                for (int i = 0; i < 3; i++)
                    c[6+i] = CW'(longint'(c[i]) + k * (longint'(c[3+i]) - longint'(c[i])));
            end else if (kind == 9) begin
                for (int i = 0; i < 3; i++) c[6+i] = c[i];
            end
            send_word(c, no_gaps ? 0 : pick_gap());
        end
    endtask

    task automatic test_random();
        send_random(190, 1'b0);
    endtask

    task automatic test_backpressure();
        hold_tog = ~hold_tog;
        send_random(200, 1'b1);
    endtask

    task automatic test_calm_stream();
        rx_calm = 1'b1;
        send_random(40, 1'b1);
        rx_calm = 1'b0;
    endtask

    always @(posedge aclk) begin
        hold_seen <= hold_tog;
        if (hold_tog != hold_seen) begin
            m_ready <= 1'b0;
            hold_req <= LONG_HOLD;
        end else if (hold_req > 0) begin
            m_ready <= 1'b0;
            hold_req <= hold_req - 1;
        end else if (rx_calm) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) < 8) ? 1'b0 :
                       ($urandom_range(0, 99) < 25 ? 1'b0 : 1'b1);
            if ($urandom_range(0, 199) == 0) hold_req <= $urandom_range(10, 60);
        end
    end

    always @(negedge aclk) begin
        angle_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected word angle=%0d degenerate=%0b",
                         $time, m_angle, m_degenerate);
                n_errors++;
            end else begin
                want = pending_angles.pop_front();
                if (m_angle !== want.angle) begin
                    $display("%0t: angle expected %0d actual %0d", $time, want.angle, m_angle);
                    n_errors++;
                end
                if (m_degenerate !== want.degen) begin
                    $display("%0t: degenerate expected %0b actual %0b",
                             $time, want.degen, m_degenerate);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_calm_stream();
        test_random();
        s_valid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (n_errors == 0 && pending_angles.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
